/* hw/rtl/mmf_pkg.sv */
// Shared types and constants for the moving median filter.
package mmf_pkg;

   // Default sizing handed to the top level parameters
   localparam int WINDOW_MAX_DEF   = 15;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Window length register
   localparam int                 CFG_WIDTH     = 4;
   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 4'd5;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_PICK,
      ST_WRITE
   } state_type;

   // Per-cycle commands broadcast to every cell of the chain
   typedef struct packed {
      logic shift;   // take a new request: shift samples, reload rotation copy
      logic step;    // one ranking step: compare against broadcast, rotate copy
   } cell_ctrl_type;

endpackage

/* hw/rtl/moving_median_filter_unit.sv */
// Top level of the moving median filter: cell chain, sequencer and result register.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / stall    | sample, end_of_series
//   rsp     | out       | valid / stall    | filtered_sample, passed_through
//   csr     | in        | valid / ready    | window_length
//
// A warm-up request goes through accept and write. A median request goes through
// accept, m ranking steps, pick and write; the ranking sweep rotates the window
// through the cell chain one sample per cycle.
// Reset is synchronous; it clears the sequencer, series count, result valid and
// sets window_length to 5. A new request is accepted while a result waits under
// stall; the write step then holds until the result register frees up.
module moving_median_filter_unit import mmf_pkg::*; #(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_end_of_series,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   output logic                           rsp_passed_through,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CFG_WIDTH-1:0]    csr_window_length
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

   state_type                      state_ff, state_in;
   logic        [CFG_WIDTH-1:0]    window_length_ff, window_length_in;
   logic        [CW-1:0]           count_ff, count_in;
   logic        [CW-1:0]           m_ff, m_in;
   logic        [CW-1:0]           k_ff, k_in;
   logic                           pass_ff, pass_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_pass_ff, rsp_pass_in;

   logic                           accept;
   logic                           load;
   logic                           pick_en;
   logic        [LW-1:0]           cfg_ext;
   logic        [CW-1:0]           m_now;
   logic                           pass_now;
   cell_ctrl_type                  ctrl;
   logic signed [SAMPLE_WIDTH-1:0] median;

   logic signed [SAMPLE_WIDTH-1:0] samples_w [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] rot_w     [WINDOW_MAX];
   logic        [CW-1:0]           ranks_w   [WINDOW_MAX];

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Clamp the window length into one to WINDOW_MAX
   always_comb begin
      cfg_ext = LW'(window_length_ff);
      if (cfg_ext == '0) begin
         m_now = CW'(1);
      end else if (cfg_ext > LW'(WINDOW_MAX)) begin
         m_now = CW'(WINDOW_MAX);
      end else begin
         m_now = CW'(cfg_ext);
      end
   end

   assign pass_now = count_ff < m_now;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = pass_now ? ST_WRITE : ST_RANK;
         end
         ST_RANK: begin
            if (k_ff == m_ff - CW'(1)) state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      ctrl.shift = 1'b0;
      ctrl.step  = 1'b0;
      pick_en    = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctrl.shift = req_valid;
         end
         ST_RANK: begin
            ctrl.step = 1'b1;
         end
         ST_PICK: begin
            pick_en = 1'b1;
         end
         ST_WRITE: begin
            load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Series count, window length capture, step index and result register
   always_comb begin
      window_length_in = window_length_ff;
      if (csr_valid && csr_ready) window_length_in = csr_window_length;

      count_in = count_ff;
      m_in     = m_ff;
      pass_in  = pass_ff;
      if (accept) begin
         m_in    = m_now;
         pass_in = pass_now;
         if (req_end_of_series) begin
            count_in = '0;
         end else if (count_ff < CW'(WINDOW_MAX)) begin
            count_in = count_ff + CW'(1);
         end
      end

      k_in = ctrl.step ? k_ff + CW'(1) : '0;

      rsp_sample_in = rsp_sample_ff;
      rsp_pass_in   = rsp_pass_ff;
      if (load) begin
         rsp_sample_in = pass_ff ? samples_w[0] : median;
         rsp_pass_in   = pass_ff;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_length_ff <= WINDOW_RESET;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         k_ff             <= '0;
      end else begin
         state_ff         <= state_in;
         window_length_ff <= window_length_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
         k_ff             <= k_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      pass_ff       <= pass_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_pass_ff   <= rsp_pass_in;
   end

   // Cell chain: samples move away from cell zero, rotation copies move toward it
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] s_in;
      logic signed [SAMPLE_WIDTH-1:0] r_in;
      if (i == 0) begin : g_head
         assign s_in = req_sample;
      end else begin : g_body
         assign s_in = samples_w[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_tail
         assign r_in = samples_w[i];
      end else begin : g_link
         assign r_in = rot_w[i+1];
      end
      mmf_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .CW           (CW),
         .IDX          (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sample_in  (s_in),
         .sample_out (samples_w[i]),
         .rot_in     (r_in),
         .rot_out    (rot_w[i]),
         .bcast      (rot_w[0]),
         .step_idx   (k_ff),
         .rank_out   (ranks_w[i])
      );
   end

   mmf_picker #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CW           (CW)
   ) u_picker (
      .clock   (clock),
      .pick_en (pick_en),
      .win_len (m_ff),
      .samples (samples_w),
      .ranks   (ranks_w),
      .median  (median)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_passed_through  = rsp_pass_ff;

endmodule

/* hw/rtl/mmf_cell.sv */
// One window cell: holds a sample, a rotating copy for broadcast, and its rank.
module mmf_cell import mmf_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int CW           = 4,
   parameter int IDX          = 0
) (
   input  logic                           clock,
   input  cell_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out,
   input  logic signed [SAMPLE_WIDTH-1:0] rot_in,
   output logic signed [SAMPLE_WIDTH-1:0] rot_out,
   input  logic signed [SAMPLE_WIDTH-1:0] bcast,
   input  logic        [CW-1:0]           step_idx,
   output logic        [CW-1:0]           rank_out
);

   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic signed [SAMPLE_WIDTH-1:0] copy_ff, copy_in;
   logic        [CW-1:0]           rank_ff, rank_in;
   logic                           below;

   // Broadcast value sorts ahead of this cell; ties go to the lower, newer position index
   assign below = (bcast < value_ff) ||
                  ((bcast == value_ff) && (step_idx < CW'(IDX)));

   // Next values
   always_comb begin
      value_in = value_ff;
      copy_in  = copy_ff;
      rank_in  = rank_ff;
      if (ctrl.shift) begin
         value_in = sample_in;
         copy_in  = sample_in;
         rank_in  = '0;
      end else if (ctrl.step) begin
         copy_in = rot_in;
         if (below) begin
            rank_in = rank_ff + CW'(1);
         end
      end
   end

   // Hold cell contents
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      copy_ff  <= copy_in;
      rank_ff  <= rank_in;
   end

   assign sample_out = value_ff;
   assign rot_out    = copy_ff;
   assign rank_out   = rank_ff;

endmodule

/* hw/rtl/mmf_picker.sv */
// Median pick: select the middle-ranked cells and form the floor of their mean.
module mmf_picker import mmf_pkg::*; #(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int CW           = 4
) (
   input  logic                           clock,
   input  logic                           pick_en,
   input  logic        [CW-1:0]           win_len,
   input  logic signed [SAMPLE_WIDTH-1:0] samples [WINDOW_MAX],
   input  logic        [CW-1:0]           ranks   [WINDOW_MAX],
   output logic signed [SAMPLE_WIDTH-1:0] median
);

   logic        [CW-1:0]           lo_rank, hi_rank;
   logic        [SAMPLE_WIDTH-1:0] lo_sel, hi_sel;
   logic signed [SAMPLE_WIDTH-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SAMPLE_WIDTH:0]   sum;

   // Middle ranks: equal for an odd window, adjacent for an even one
   assign lo_rank = (win_len - CW'(1)) >> 1;
   assign hi_rank = win_len >> 1;

   // Select among cells inside the window; ranks there are unique
   always_comb begin
      lo_sel = '0;
      hi_sel = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (CW'(i) < win_len) begin
            if (ranks[i] == lo_rank) lo_sel = lo_sel | samples[i];
            if (ranks[i] == hi_rank) hi_sel = hi_sel | samples[i];
         end
      end
      lo_in = pick_en ? $signed(lo_sel) : lo_ff;
      hi_in = pick_en ? $signed(hi_sel) : hi_ff;
   end

   // Hold the two middle values
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // Floor of the mean: arithmetic shift of the widened sum
   assign sum    = {lo_ff[SAMPLE_WIDTH-1], lo_ff} + {hi_ff[SAMPLE_WIDTH-1], hi_ff};
   assign median = sum[SAMPLE_WIDTH:1];

endmodule
